// ----- rtl/core/skt_pkg.sv -----
// Shared constants and types for the sorted keyframe table.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int TIME_WIDTH  = 32;
  localparam int TOL_WIDTH   = 32;
  localparam int VAL_WIDTH   = 32;
  localparam int FIELD_WIDTH = 5;
  localparam int CNT_WIDTH   = $clog2(TABLE_DEPTH + 1);
  localparam int DIFF_WIDTH  = (TIME_WIDTH > TOL_WIDTH) ? TIME_WIDTH : TOL_WIDTH;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);

  typedef struct packed {
    logic [TIME_WIDTH-1:0]       key_time;
    logic signed [VAL_WIDTH-1:0] value_x;
    logic signed [VAL_WIDTH-1:0] value_y;
    logic signed [VAL_WIDTH-1:0] value_z;
    logic signed [VAL_WIDTH-1:0] value_w;
  } entry_t;

  typedef struct packed {
    logic ins;        // insert beat this cycle
    logic occ;        // cell holds a stored key
    logic take_prev;  // left neighbor is at or past the insert point
  } cell_ctl_t;

endpackage

// ----- rtl/core/skt_in_if.sv -----
// Input channel: one keyframe insert or query beat.
`timescale 1ns / 1ps

interface skt_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] key_time;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  logic signed [31:0] value_z;
  logic signed [31:0] value_w;

  modport source (output valid, mode, key_time, value_x, value_y, value_z, value_w,
                  input ready);
  modport sink   (input valid, mode, key_time, value_x, value_y, value_z, value_w,
                  output ready);
endinterface

// ----- rtl/core/skt_out_if.sv -----
// Output channel: one result beat per accepted item.
`timescale 1ns / 1ps

interface skt_out_if;
  logic       valid;
  logic       ready;
  logic       inserted;
  logic       dropped_full;
  logic       found;
  logic [4:0] slot_index;
  logic [4:0] entry_count;

  modport source (output valid, inserted, dropped_full, found, slot_index, entry_count,
                  input ready);
  modport sink   (input valid, inserted, dropped_full, found, slot_index, entry_count,
                  output ready);
endinterface

// ----- rtl/core/skt_cell.sv -----
// One table cell: holds a keyframe, compares against the broadcast key, shifts right.
`timescale 1ns / 1ps

module skt_cell (
  input  logic                             clk_i,
  input  skt_pkg::cell_ctl_t               ctl_i,
  input  skt_pkg::entry_t                  new_i,
  input  logic [skt_pkg::TOL_WIDTH-1:0]    tol_i,
  input  skt_pkg::entry_t                  prev_i,
  output skt_pkg::entry_t                  entry_o,
  output logic                             take_o,
  output logic                             match_o
);

  skt_pkg::entry_t entry_q, entry_d;
  logic [skt_pkg::TIME_WIDTH-1:0] diff;

  // Free cells and cells holding a later time sit at or past the insert point.
  assign take_o = !ctl_i.occ || (entry_q.key_time > new_i.key_time);

  always_comb begin
    if (entry_q.key_time >= new_i.key_time) begin
      diff = entry_q.key_time - new_i.key_time;
    end else begin
      diff = new_i.key_time - entry_q.key_time;
    end
  end

  assign match_o = ctl_i.occ &&
                   (skt_pkg::DIFF_WIDTH'(diff) < skt_pkg::DIFF_WIDTH'(tol_i));

  always_comb begin
    priority if (ctl_i.ins && ctl_i.take_prev) begin
      entry_d = prev_i;
    end else if (ctl_i.ins && take_o) begin
      entry_d = new_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- rtl/core/sorted_keyframe_table_core.sv -----
// Top level of the sorted keyframe table: cell row, fill count and result register.
`timescale 1ns / 1ps

// Sorted keyframe table. Holds up to TABLE_DEPTH keyframes in time order in a
// row of cells; an insert lands before the first stored time that is strictly
// greater (equal times keep arrival order) and a full table drops it, while a
// query reports whether any stored time lies strictly within the tolerance of
// the key. The key is broadcast to every cell, all cells compare and shift in
// the cycle in which the item is accepted, and the result is registered and
// shown in the cycle after. A new item is accepted every cycle as long as the
// result register is empty or being drained, so the sustained rate is one item
// per cycle. The user must write the tolerance register (reset 1) only while
// the block is idle; the block itself does not enforce this.

module sorted_keyframe_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  skt_in_if.sink      in_i,
  skt_out_if.source   out_o
);

  localparam int N = skt_pkg::TABLE_DEPTH;
  localparam int CW = skt_pkg::CNT_WIDTH;

  logic [skt_pkg::TOL_WIDTH-1:0] tol_q;
  logic [CW-1:0] count_q, count_d;
  logic          accept, is_ins, is_qry, full, do_ins;
  logic          found;
  logic [CW-1:0] slot;

  skt_pkg::entry_t    new_entry;
  skt_pkg::entry_t    cell_entry [N];
  skt_pkg::cell_ctl_t cell_ctl   [N];
  logic [N-1:0]       take, match, first;

  logic          out_valid_q;
  logic          inserted_q, dropped_q, found_q;
  logic [skt_pkg::FIELD_WIDTH-1:0] slot_q, count_out_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_ins     = accept && (in_i.mode == skt_pkg::MODE_INSERT);
  assign is_qry     = accept && (in_i.mode == skt_pkg::MODE_QUERY);
  assign full       = (count_q >= CW'(N));
  assign do_ins     = is_ins && !full;

  assign new_entry.key_time = in_i.key_time[skt_pkg::TIME_WIDTH-1:0];
  assign new_entry.value_x  = in_i.value_x;
  assign new_entry.value_y  = in_i.value_y;
  assign new_entry.value_z  = in_i.value_z;
  assign new_entry.value_w  = in_i.value_w;

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);

    assign cell_ctl[i].ins       = do_ins;
    assign cell_ctl[i].occ       = IDX < count_q;
    if (i == 0) begin : g_head
      assign cell_ctl[i].take_prev = 1'b0;
      assign first[i]              = take[i];
      skt_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (cell_ctl[i]),
        .new_i   (new_entry),
        .tol_i   (tol_q),
        .prev_i  (new_entry),
        .entry_o (cell_entry[i]),
        .take_o  (take[i]),
        .match_o (match[i])
      );
    end else begin : g_body
      assign cell_ctl[i].take_prev = take[i-1];
      assign first[i]              = take[i] && !take[i-1];
      skt_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (cell_ctl[i]),
        .new_i   (new_entry),
        .tol_i   (tol_q),
        .prev_i  (cell_entry[i-1]),
        .entry_o (cell_entry[i]),
        .take_o  (take[i]),
        .match_o (match[i])
      );
    end
  end

  // Insert point is the single cell whose left neighbor stays put.
  always_comb begin
    slot = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) begin
        slot = slot | CW'(i);
      end
    end
  end

  assign found = |match;

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= skt_pkg::TOL_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i[skt_pkg::TOL_WIDTH-1:0];
      end
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inserted_q  <= do_ins;
      dropped_q   <= is_ins && full;
      found_q     <= is_qry && found;
      slot_q      <= do_ins ? skt_pkg::FIELD_WIDTH'(slot) : '0;
      count_out_q <= skt_pkg::FIELD_WIDTH'(count_d);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.inserted     = inserted_q;
  assign out_o.dropped_full = dropped_q;
  assign out_o.found        = found_q;
  assign out_o.slot_index   = slot_q;
  assign out_o.entry_count  = count_out_q;

endmodule

// ----- rtl/core/skt_checker.sv -----
// Port-level assertions for the sorted keyframe table, bound to the top level.
`timescale 1ns / 1ps

module skt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       inserted_i,
  input logic       dropped_full_i,
  input logic       found_i,
  input logic [4:0] slot_index_i,
  input logic [4:0] entry_count_i
);

  localparam logic [4:0] FULL_COUNT = 5'(skt_pkg::TABLE_DEPTH);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({inserted_i, dropped_full_i, found_i, slot_index_i, entry_count_i}))
    else $error("result beat changed while stalled");

  // Every accepted item shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item produced no result");

  // A drop happens only on a full table and reports no slot.
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dropped_full_i |->
      entry_count_i == FULL_COUNT && slot_index_i == 5'd0 && !inserted_i && !found_i)
    else $error("drop reported on a table that is not full");

  // An insert lands inside the table it just grew.
  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && inserted_i |-> slot_index_i < entry_count_i && !found_i)
    else $error("insert slot outside stored entries");

endmodule

bind sorted_keyframe_table_core skt_checker u_skt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .inserted_i     (out_o.inserted),
  .dropped_full_i (out_o.dropped_full),
  .found_i        (out_o.found),
  .slot_index_i   (out_o.slot_index),
  .entry_count_i  (out_o.entry_count)
);

// ----- tb/tb.sv -----
// Testbench for the sorted keyframe table: directed and random insert/query traffic.
`timescale 1ns / 1ps

module tb;
  import skt_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic       inserted;
    logic       dropped_full;
    logic       found;
    logic [4:0] slot_index;
    logic [4:0] entry_count;
  } keyframe_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  skt_in_if  in_if();
  skt_out_if out_if();

  sorted_keyframe_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Shadow of the table contents and the tolerance register
  entry_t                 keyframes [TABLE_DEPTH];
  int                     stored_count;
  logic [TOL_WIDTH-1:0]   tolerance;
  keyframe_result_t       expected_results [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  error_count;
  int  cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic keyframe_result_t apply_keyframe(logic mode, entry_t e);
    keyframe_result_t     r;
    int                   pos;
    int                   i;
    logic                 hit;
    logic [DIFF_WIDTH-1:0] d;
    r = '0;
    if (mode == MODE_INSERT) begin
      if (stored_count >= TABLE_DEPTH) begin
        r.dropped_full = 1'b1;
      end else begin
        pos = stored_count;
        hit = 1'b0;
        // First stored time strictly greater marks the insert point
        for (i = 0; i < stored_count; i++) begin
          if (!hit && keyframes[i].key_time > e.key_time) begin
            pos = i;
            hit = 1'b1;
          end
        end
        for (i = stored_count; i > pos; i--) keyframes[i] = keyframes[i-1];
        keyframes[pos] = e;
        stored_count++;
        r.inserted = 1'b1;
        r.slot_index = pos[4:0];
      end
    end else begin
      for (i = 0; i < stored_count; i++) begin
        d = (keyframes[i].key_time >= e.key_time) ? keyframes[i].key_time - e.key_time
                                                 : e.key_time - keyframes[i].key_time;
        if (d < tolerance) r.found = 1'b1;
      end
    end
    r.entry_count = stored_count[4:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [4:0] exp_v, logic [4:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    keyframe_result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %b/%b/%b/%0d/%0d",
                 $time, out_if.inserted, out_if.dropped_full, out_if.found,
                 out_if.slot_index, out_if.entry_count);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("inserted", exp_r.inserted, out_if.inserted);
        check_field("dropped_full", exp_r.dropped_full, out_if.dropped_full);
        check_field("found", exp_r.found, out_if.found);
        check_field("slot_index", exp_r.slot_index, out_if.slot_index);
        check_field("entry_count", exp_r.entry_count, out_if.entry_count);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic mode, entry_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    = 1'b1;
    in_if.mode     = mode;
    in_if.key_time = e.key_time;
    in_if.value_x  = e.value_x;
    in_if.value_y  = e.value_y;
    in_if.value_z  = e.value_z;
    in_if.value_w  = e.value_w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_results.insert(expected_results.size(), apply_keyframe(mode, e));
    @(negedge clk_i);
  endtask

  task automatic send_simple(logic mode, logic [31:0] key);
    entry_t e;
    e = '{key_time: key, value_x: $urandom, value_y: $urandom, value_z: $urandom,
          value_w: $urandom};
    send_item(mode, e);
  endtask

  // Drain all results, then write the tolerance while the block is idle
  task automatic set_tolerance(logic [31:0] value);
    in_if.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i  = 1'b0;
    tolerance = value;
  endtask

  task automatic test_empty_query();
    send_simple(MODE_QUERY, 32'h0);
    send_simple(MODE_QUERY, 32'hFFFF_FFFF);
  endtask

  task automatic test_insert_order();
    entry_t e;
    e = '{key_time: 32'h8000_0000, value_x: 32'h7FFF_FFFF, value_y: 32'h8000_0000,
          value_z: 32'h0, value_w: 32'hFFFF_FFFF};
    send_item(MODE_INSERT, e);
    // Equal time lands after the earlier arrival
    e = '{key_time: 32'h8000_0000, value_x: 32'h8000_0000, value_y: 32'h7FFF_FFFF,
          value_z: 32'hFFFF_FFFF, value_w: 32'h0};
    send_item(MODE_INSERT, e);
    send_simple(MODE_INSERT, 32'h0);
    e = '{key_time: 32'hFFFF_FFFF, value_x: 32'h0, value_y: 32'h0,
          value_z: 32'h7FFF_FFFF, value_w: 32'h8000_0000};
    send_item(MODE_INSERT, e);
    send_simple(MODE_INSERT, 32'h7FFF_FFFF);
    send_simple(MODE_QUERY, 32'h8000_0000);
    send_simple(MODE_QUERY, 32'h8000_0001);
    send_simple(MODE_QUERY, 32'h0000_0001);
  endtask

  task automatic test_tolerance();
    set_tolerance(32'h0);
    send_simple(MODE_QUERY, 32'h8000_0000);
    send_simple(MODE_QUERY, 32'h0);
    set_tolerance(32'h2);
    send_simple(MODE_QUERY, 32'h8000_0001);
    send_simple(MODE_QUERY, 32'h8000_0002);
    send_simple(MODE_QUERY, 32'hFFFF_FFFE);
    set_tolerance(32'hFFFF_FFFF);
    send_simple(MODE_QUERY, 32'h4000_0000);
    send_simple(MODE_QUERY, 32'hFFFF_FFFF);
  endtask

  // Pick a time near the stored keys, or sometimes a random one, so queries both hit and miss
  function automatic logic [31:0] pick_time();
    logic [31:0] base;
    if (stored_count == 0 || $urandom_range(3) == 0) return $urandom;
    base = keyframes[$urandom_range(stored_count - 1)].key_time;
    case ($urandom_range(2))
      0: return base;
      1: return base + 32'($urandom_range(8)) - 32'd4;
      default: return ($urandom_range(1)) ? base + tolerance - 32'($urandom_range(1))
                                          : base - tolerance + 32'($urandom_range(1));
    endcase
  endfunction

  task automatic test_random_traffic(int n_items);
    int k;
    for (k = 0; k < n_items; k++) begin
      send_simple(($urandom_range(99) < 35) ? MODE_INSERT : MODE_QUERY, pick_time());
    end
  endtask

  initial begin
    logic [31:0] tol_list [8];
    int          ph;
    tol_list = '{32'h1, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 32'h2,
                 32'h0000_0010, 32'h0};
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_if.valid    = 1'b0;
    in_if.mode     = MODE_INSERT;
    in_if.key_time = '0;
    in_if.value_x  = '0;
    in_if.value_y  = '0;
    in_if.value_z  = '0;
    in_if.value_w  = '0;
    out_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    cycle_count    = 0;
    stored_count   = 0;
    tolerance      = TOL_RESET;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_query();
    test_insert_order();
    test_tolerance();

    tol_list[7] = $urandom;
    for (ph = 0; ph < 8; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      set_tolerance(tol_list[ph]);
      test_random_traffic(215);
    end

    in_if.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
